// ----- src/hvt_pkg.sv -----
// Shared types and constants for the homogeneous vertex transform.
// Holds the decoded queue entry and the stream field layout; no dependencies.
package hvt_pkg;

   localparam int VEC_WIDTH   = 32;
   localparam int NUM_DIM     = 4;
   localparam int IDX_WIDTH   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = 2;
   localparam int QCNT_WIDTH  = 3;

   // Request tdata layout, lowest bit first
   localparam int REQ_ROW_LSB   = 0;
   localparam int REQ_COL_LSB   = 2;
   localparam int REQ_COEFF_LSB = 4;
   localparam int REQ_VEC_LSB   = 36;
   localparam int REQ_TDATA_W   = 168;
   localparam int RSP_TDATA_W   = 128;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_XFORM = 1'b1;

   typedef struct packed {
      logic                                is_load;
      logic [IDX_WIDTH-1:0]                idx;
      logic [VEC_WIDTH-1:0]                coeff;
      logic [NUM_DIM-1:0][VEC_WIDTH-1:0]   vec;
   } hvt_op_type;

endpackage

// ----- src/hvt_front.sv -----
// Front end: accepts requests, decodes load vs. transform, queues them in order.
// Depends on hvt_pkg.
module hvt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hvt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic                                op_valid,
   output hvt_pkg::hvt_op_type                 op,
   input  logic                                op_pop
);
   import hvt_pkg::*;

   hvt_op_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff,  count_in;
   hvt_op_type             dec;
   logic                   push;

   always_comb begin
      dec.is_load = (req_tuser == CMD_LOAD);
      dec.idx     = {req_tdata[REQ_ROW_LSB +: 2], req_tdata[REQ_COL_LSB +: 2]};
      dec.coeff   = req_tdata[REQ_COEFF_LSB +: VEC_WIDTH];
      for (int i = 0; i < NUM_DIM; i++) begin
         dec.vec[i] = req_tdata[REQ_VEC_LSB + i*VEC_WIDTH +: VEC_WIDTH];
      end
   end

   assign req_tready = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign op_valid   = (count_ff != '0);
   assign op         = q_ff[rd_ptr_ff];

   assign wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = op_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_WIDTH'(push) - QCNT_WIDTH'(op_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

// ----- src/hvt_back.sv -----
// Back end: coefficient store, 16 parallel products, column sums, shift and clamp.
// Depends on hvt_pkg; fed in order from hvt_front.
module hvt_back #(
   parameter int COEFF_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                op_valid,
   input  hvt_pkg::hvt_op_type                 op,
   output logic                                op_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hvt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);
   import hvt_pkg::*;

   localparam int CW = (COEFF_WIDTH < VEC_WIDTH) ? COEFF_WIDTH : VEC_WIDTH;
   localparam int PW = VEC_WIDTH + CW;
   localparam int SW = PW + 2;
   localparam logic [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);

   logic signed [CW-1:0]        mat_ff  [NUM_DIM*NUM_DIM];
   logic signed [PW-1:0]        prod_ff [NUM_DIM][NUM_DIM];
   logic signed [PW-1:0]        prod_in [NUM_DIM][NUM_DIM];
   logic signed [SW-1:0]        sum_ff  [NUM_DIM];
   logic signed [SW-1:0]        sum_in  [NUM_DIM];
   logic signed [SW-1:0]        shifted [NUM_DIM];
   logic [VEC_WIDTH-1:0]        out_ff  [NUM_DIM];
   logic [VEC_WIDTH-1:0]        out_in  [NUM_DIM];
   logic [NUM_DIM-1:0]          clamp;
   logic                        sat_ff, sat_in;
   logic                        v_mul_ff, v_sum_ff, out_valid_ff;
   logic                        advance;
   logic                        load_now;

   assign advance  = !out_valid_ff || rsp_tready;
   assign load_now = op_valid && op.is_load;
   assign op_pop   = op_valid && (op.is_load || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_DIM; r++) begin
            for (int c = 0; c < NUM_DIM; c++) begin
               mat_ff[r*NUM_DIM+c] <= (r == c) ? ONE : '0;
            end
         end
      end else if (load_now) begin
         mat_ff[op.idx] <= op.coeff[CW-1:0];
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_DIM; r++) begin
         for (int c = 0; c < NUM_DIM; c++) begin
            prod_in[r][c] = $signed(op.vec[r]) * mat_ff[r*NUM_DIM+c];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_DIM; c++) begin
         sum_in[c] = SW'(prod_ff[0][c]) + SW'(prod_ff[1][c])
                   + SW'(prod_ff[2][c]) + SW'(prod_ff[3][c]);
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_DIM; c++) begin
         shifted[c] = sum_ff[c] >>> FRAC_BITS;
         clamp[c]   = !((&shifted[c][SW-1:VEC_WIDTH-1]) || !(|shifted[c][SW-1:VEC_WIDTH-1]));
         if (!clamp[c]) begin
            out_in[c] = shifted[c][VEC_WIDTH-1:0];
         end else if (shifted[c][SW-1]) begin
            out_in[c] = {1'b1, {(VEC_WIDTH-1){1'b0}}};
         end else begin
            out_in[c] = {1'b0, {(VEC_WIDTH-1){1'b1}}};
         end
      end
      sat_in = |clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_mul_ff     <= 1'b0;
         v_sum_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v_mul_ff     <= op_valid && !op.is_load;
         v_sum_ff     <= v_mul_ff;
         out_valid_ff <= v_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff[3], out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tuser  = sat_ff;

`ifndef SYNTHESIS
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (load_now && advance) |=> !v_mul_ff)
      else $error("load entered the multiply stage");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v_mul_ff) && $stable(v_sum_ff))
      else $error("pipeline moved during stall");
   a_reset_identity: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (mat_ff[0] == ONE) && (mat_ff[1] == '0))
      else $error("matrix not identity after reset");
`endif

endmodule

// ----- src/homogeneous_vertex_transform.sv -----
// Homogeneous row vector times 4x4 matrix, signed fixed point, saturating.
// Throughput: one request per cycle, loads and transforms alike, while the queue is not full.
// Request to rsp_tvalid passes the queue, product and sum registers; clamp into output reg.
// Reset: synchronous; matrix returns to identity, queue and pipeline empty.
// Depends on hvt_pkg, hvt_front, hvt_back.
module homogeneous_vertex_transform #(
   parameter int COEFF_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row_index[1:0], col_index[3:2], coeff_value[35:4], vec_x, vec_y, vec_z, vec_w, zero pad
   input  logic [hvt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_x[31:0], out_y, out_z, out_w
   output logic [hvt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // saturated
   output logic                                rsp_tuser
);
   import hvt_pkg::*;

   hvt_op_type op;
   logic       op_valid;
   logic       op_pop;

   hvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (op_valid),
      .op         (op),
      .op_pop     (op_pop)
   );

   hvt_back #(
      .COEFF_WIDTH (COEFF_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op         (op),
      .op_pop     (op_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- test/hvt_result_checker.sv -----
// Result checker for homogeneous_vertex_transform: watches both stream channels,
// keeps its own copy of the matrix and predicts every transform. Depends on hvt_pkg.
module hvt_result_checker #(
   parameter int COEFF_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [hvt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [hvt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   output int                              error_count,
   output int                              pending_count,
   output int                              load_count,
   output int                              vertex_count,
   output int                              clamp_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hvt_pkg::*;

   typedef struct packed {
      logic [NUM_DIM-1:0][VEC_WIDTH-1:0] comp;
      logic                              sat;
   } vertex_out_type;

   logic signed [VEC_WIDTH-1:0] coeff_mem [NUM_DIM][NUM_DIM];
   vertex_out_type              vertex_q [$];
   string                       comp_name [NUM_DIM] = '{"out_x", "out_y", "out_z", "out_w"};

   // keep the low COEFF_WIDTH bits (at most 32) and sign-extend from there
   function automatic logic signed [VEC_WIDTH-1:0] fit_coeff(input logic [VEC_WIDTH-1:0] raw);
      int                          drop;
      logic signed [VEC_WIDTH-1:0] t;
      drop = (COEFF_WIDTH < VEC_WIDTH) ? VEC_WIDTH - COEFF_WIDTH : 0;
      t = raw << drop;
      return t >>> drop;
   endfunction

   function automatic vertex_out_type transform_vertex(
      input logic [NUM_DIM-1:0][VEC_WIDTH-1:0] v);
      vertex_out_type     res;
      logic signed [65:0] acc;
      logic signed [65:0] shifted;
      res.sat = 1'b0;
      for (int c = 0; c < NUM_DIM; c++) begin
         acc = '0;
         for (int r = 0; r < NUM_DIM; r++)
            acc += $signed(v[r]) * coeff_mem[r][c];
         shifted = acc >>> FRAC_BITS;
         if (shifted > 66'sd2147483647) begin
            res.comp[c] = 32'h7FFF_FFFF;
            res.sat = 1'b1;
         end else if (shifted < -66'sd2147483648) begin
            res.comp[c] = 32'h8000_0000;
            res.sat = 1'b1;
         end else begin
            res.comp[c] = shifted[VEC_WIDTH-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      vertex_out_type                    want;
      logic [NUM_DIM-1:0][VEC_WIDTH-1:0] got;
      if (reset) begin
         for (int r = 0; r < NUM_DIM; r++)
            for (int c = 0; c < NUM_DIM; c++)
               coeff_mem[r][c] = (r == c) ? fit_coeff(32'd1 << FRAC_BITS) : '0;
         vertex_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_q.size() == 0) begin
               $error("result with no transform pending: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = vertex_q.pop_front();
               got  = rsp_tdata;
               for (int c = 0; c < NUM_DIM; c++) begin
                  if (got[c] !== want.comp[c]) begin
                     $error("%s: expected %h, got %h", comp_name[c], want.comp[c], got[c]);
                     error_count++;
                  end
               end
               if (rsp_tuser !== want.sat) begin
                  $error("saturated: expected %b, got %b", want.sat, rsp_tuser);
                  error_count++;
               end
               if (want.sat)
                  clamp_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD) begin
               coeff_mem[req_tdata[REQ_ROW_LSB +: 2]][req_tdata[REQ_COL_LSB +: 2]] =
                  fit_coeff(req_tdata[REQ_COEFF_LSB +: VEC_WIDTH]);
               load_count++;
            end else begin
               vertex_q.push_back(transform_vertex(req_tdata[REQ_VEC_LSB +: NUM_DIM*VEC_WIDTH]));
               vertex_count++;
            end
         end
      end
      pending_count = vertex_q.size();
   end

endmodule

// ----- test/tb_homogeneous_vertex_transform.sv -----
// Top of the homogeneous_vertex_transform testbench: clock, reset, request and
// result stimulus, watchdog and verdict. Depends on hvt_pkg, homogeneous_vertex_transform, hvt_result_checker.
module tb_homogeneous_vertex_transform;
   timeunit 1ns;
   timeprecision 1ps;
   import hvt_pkg::*;

   localparam int COEFF_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int IDLE_LIMIT  = 500;
   localparam int HOLD_CYCLES = 48;
   localparam int DRAIN       = 8;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = CMD_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   int error_count, pending_count, load_count, vertex_count, clamp_count;
   int request_count = 0;
   int idle_cycles   = 0;
   bit steady_send   = 1'b0;
   bit steady_recv   = 1'b0;
   bit hold_rsp      = 1'b0;

   homogeneous_vertex_transform #(
      .COEFF_WIDTH(COEFF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   hvt_result_checker #(
      .COEFF_WIDTH(COEFF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .error_count  (error_count),
      .pending_count(pending_count),
      .load_count   (load_count),
      .vertex_count (vertex_count),
      .clamp_count  (clamp_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
            $display("tb_homogeneous_vertex_transform: done, errors");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_q();
      logic [31:0] mag;
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: begin
            mag = $urandom_range(0, 32'h3_FFFF);
            return $urandom_range(0, 1) ? -mag : mag;
         end
         3: begin
            mag = $urandom_range(0, 32'h7F_FFFF);
            return $urandom_range(0, 1) ? -mag : mag;
         end
         4: begin
            case ($urandom_range(0, 5))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               4: return 32'h1;
               default: return 32'h0001_0000;
            endcase
         end
         default: begin
            mag = $urandom_range(0, 16) << FRAC_BITS;
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_coeff();
      logic [31:0] mag;
      if ($urandom_range(0, 9) < 6) begin
         mag = $urandom_range(0, 32'h3_0000);
         return $urandom_range(0, 1) ? -mag : mag;
      end
      return pick_q();
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] pack_request(
      input logic [1:0] row, input logic [1:0] col, input logic [31:0] coeff,
      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z, input logic [31:0] w);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[REQ_ROW_LSB +: 2]    = row;
      d[REQ_COL_LSB +: 2]    = col;
      d[REQ_COEFF_LSB +: 32] = coeff;
      d[REQ_VEC_LSB +: 128]  = {w, z, y, x};
      return d;
   endfunction

   task automatic send_request(input logic cmd, input logic [REQ_TDATA_W-1:0] data);
      int gap;
      gap = steady_send ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
   endtask

   // vector fields are don't-care on a load
   task automatic load_coeff(input logic [1:0] row, input logic [1:0] col,
                             input logic [31:0] coeff);
      send_request(CMD_LOAD, pack_request(row, col, coeff, $urandom, $urandom, $urandom, $urandom));
   endtask

   // index and coefficient fields are don't-care on a transform
   task automatic transform(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] w);
      send_request(CMD_XFORM, pack_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                           $urandom, x, y, z, w));
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = steady_recv ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      int load_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix after reset, then all-zero vector
      transform(32'h0001_0000, 32'hFFFF_0000, Q_MAX, Q_MIN);
      transform(32'h0, 32'h0, 32'h0, 32'h0);
      // extreme columns: sums beyond 64 bits in both directions
      for (int r = 0; r < 4; r++) begin
         load_coeff(r[1:0], 2'd0, Q_MAX);
         load_coeff(r[1:0], 2'd1, Q_MIN);
      end
      transform(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      transform(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      transform(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      // truncation toward minus infinity on a tiny negative product
      load_coeff(2'd0, 2'd2, 32'h1);
      transform(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      load_coeff(2'd3, 2'd3, 32'h0);
      load_coeff(2'd3, 2'd2, 32'hFFFF_FFFF);
      transform(32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_0000);
      transform(32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001, 32'h8000_0001);

      for (int phase = 0; phase < 31; phase++) begin
         steady_send = (phase % 4 == 1) || (phase == 6) || (phase == 21);
         steady_recv = (phase % 4 == 1);
         load_pct    = $urandom_range(10, 60);
         if (phase == 6 || phase == 21) begin
            hold_rsp = 1'b1;
            load_pct = 0;
         end
         for (int n = 0; n < 30; n++) begin
            if ($urandom_range(0, 99) < load_pct)
               load_coeff(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_coeff());
            else
               transform(pick_q(), pick_q(), pick_q(), pick_q());
         end
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("sent %0d requests: %0d coefficient loads, %0d vertex transforms",
               request_count, load_count, vertex_count);
      $display("%0d results were clamped; receiver held off twice for %0d cycles",
               clamp_count, HOLD_CYCLES);
      if (error_count == 0)
         $display("tb_homogeneous_vertex_transform: done, clean");
      else
         $display("tb_homogeneous_vertex_transform: done, errors");
      $finish;
   end

endmodule
